### hdl/psg_tone_noise_generator_defines.svh
// ----------------------------------------------------------------------------
// PSG assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_GENERATOR_DEFINES_SVH
`define PSG_TONE_NOISE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define PSG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("psg: assertion failed");
// Antecedent implies consequent on the next clock edge
`define PSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("psg: assertion failed");
`else
`define PSG_ASSERT(lbl, clk, rstn, prop)
`define PSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/psg_pkg.sv
// ----------------------------------------------------------------------------
// PSG package
// Shared widths, codes, the register bank struct and the volume table.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

  // Default phase accumulator fraction width
  localparam int unsigned PHASE_FRAC_DEF = 16;

  localparam int unsigned NUM_TONES = 3;
  localparam int unsigned CH_W      = 2;
  localparam int unsigned PERIOD_W  = 10;
  localparam int unsigned ATTEN_W   = 4;
  localparam int unsigned NCTL_W    = 3;
  localparam int unsigned SHIFT_W   = 16;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SCALE_W   = 14;
  localparam int unsigned MIX_W     = 17;
  localparam int unsigned DATA_W    = 8;

  // Step = (STEP_NUM_BASE << F) / (SAMPLE_RATE * period), rounded
  localparam int unsigned STEP_NUM_BASE = 250000;  // 4 MHz / 16
  localparam int unsigned SAMPLE_RATE   = 44100;
  localparam int unsigned ZERO_PERIOD   = 1024;    // period 0 reads as 0x400
  localparam int unsigned DEN_W         = 26;      // 44100 * 1024 < 2^26

  // Fixed noise periods
  localparam int unsigned NOISE_PER_FAST = 16;
  localparam int unsigned NOISE_PER_MID  = 32;
  localparam int unsigned NOISE_PER_SLOW = 64;

  // Noise rate codes, noise control bits 1:0
  localparam logic [1:0] NOISE_RATE_FAST  = 2'd0;
  localparam logic [1:0] NOISE_RATE_MID   = 2'd1;
  localparam logic [1:0] NOISE_RATE_SLOW  = 2'd2;
  localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;

  // Request kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Bus byte form, bit 7
  localparam logic FORM_LATCH = 1'b1;
  localparam logic FORM_DATA  = 1'b0;

  // Latch byte targets, bits 6:4
  typedef enum logic [2:0] {
    SEL_TONE0, SEL_ATTEN0, SEL_TONE1, SEL_ATTEN1,
    SEL_TONE2, SEL_ATTEN2, SEL_NOISE_CTRL, SEL_NOISE_ATTEN
  } psg_reg_sel_e;

  localparam logic [SHIFT_W-1:0] NOISE_SEED = 16'h8000;

  // Register bank as seen by the datapath
  typedef struct packed {
    logic [NUM_TONES-1:0][PERIOD_W-1:0] tone_period;
    logic [NUM_TONES-1:0][ATTEN_W-1:0]  tone_atten;
    logic [NCTL_W-1:0]                  noise_ctrl;
    logic [ATTEN_W-1:0]                 noise_atten;
    logic                               noise_reload;  // noise control written
  } psg_cfg_t;

  // Voice amplitude in Q15: round(8192 * (15 - atten) / 15)
  function automatic logic [SCALE_W-1:0] voice_scale(input logic [ATTEN_W-1:0] atten);
    logic [SCALE_W-1:0] s;
    unique case (atten)
      4'd0:  s = 14'd8192;
      4'd1:  s = 14'd7646;
      4'd2:  s = 14'd7100;
      4'd3:  s = 14'd6554;
      4'd4:  s = 14'd6007;
      4'd5:  s = 14'd5461;
      4'd6:  s = 14'd4915;
      4'd7:  s = 14'd4369;
      4'd8:  s = 14'd3823;
      4'd9:  s = 14'd3277;
      4'd10: s = 14'd2731;
      4'd11: s = 14'd2185;
      4'd12: s = 14'd1638;
      4'd13: s = 14'd1092;
      4'd14: s = 14'd546;
      4'd15: s = 14'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/psg_tone_noise_generator.sv
// ----------------------------------------------------------------------------
// PSG tone and noise generator
// Three square-wave tones and one shift-register noise voice, mixed and
// smoothed into one signed Q15 sample per tick request.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+-------------------------------
//   in      | in_valid_i / in_ready_o   | action_i (0 write, 1 tick), data_i
//   out     | out_valid_o / out_ready_i | sample_o (signed Q15)
//
// A write request leaves in_ready_o high.
// A tick runs to out_valid_o through each tone in turn in the shared divider,
// then noise, multiply and output.
// in_ready_o is low during a tick, so a new tick waits until the last one is through.
// An untaken sample holds the next tick in its final step until out_ready_i.
// Reset clears all voice state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "psg_tone_noise_generator_defines.svh"

module psg_tone_noise_generator #(
  parameter int unsigned PHASE_FRACTION_BITS = psg_pkg::PHASE_FRAC_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [psg_pkg::DATA_W-1:0]          data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [psg_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int unsigned F  = PHASE_FRACTION_BITS;
  localparam int unsigned PW = F + 1;
  localparam int unsigned MW = psg_pkg::MIX_W;
  localparam int unsigned SW = psg_pkg::SHIFT_W;
  localparam int unsigned YW = psg_pkg::SAMPLE_W;

  // Fixed noise steps, worked out at elaboration
  localparam longint unsigned NUM      = 64'(psg_pkg::STEP_NUM_BASE) << F;
  localparam longint unsigned DEN_FAST = 64'(psg_pkg::SAMPLE_RATE) * psg_pkg::NOISE_PER_FAST;
  localparam longint unsigned DEN_MID  = 64'(psg_pkg::SAMPLE_RATE) * psg_pkg::NOISE_PER_MID;
  localparam longint unsigned DEN_SLOW = 64'(psg_pkg::SAMPLE_RATE) * psg_pkg::NOISE_PER_SLOW;
  localparam logic [PW-1:0] NSTEP_FAST = PW'((NUM + DEN_FAST / 2) / DEN_FAST);
  localparam logic [PW-1:0] NSTEP_MID  = PW'((NUM + DEN_MID / 2) / DEN_MID);
  localparam logic [PW-1:0] NSTEP_SLOW = PW'((NUM + DEN_SLOW / 2) / DEN_SLOW);

  // Smoother: y = round((mix + 9*prev) / 10), divide by 10 via reciprocal
  localparam int unsigned FW          = 21;      // mix + 9*prev
  localparam int unsigned UW          = 20;      // offset sum, < 655357
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [UW-1:0] RECIP     = 20'd838861;   // ceil(2^23 / 10)
  localparam logic signed [FW-1:0] FILT_OFFSET = 21'sd327685;  // 10*32768 + 5

  localparam logic [psg_pkg::CH_W-1:0] LAST_TONE = psg_pkg::CH_W'(psg_pkg::NUM_TONES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_NOISE,
    ST_FILT_MUL,
    ST_FILT_OUT
  } state_e;

  state_e                   state_q, state_d;
  logic [psg_pkg::CH_W-1:0] ch_q, ch_d;
  logic                     out_valid_q, out_valid_d;

  psg_pkg::psg_cfg_t cfg;

  // Voice state
  logic [psg_pkg::NUM_TONES-1:0][PW-1:0] tone_phase_q;
  logic [PW-1:0]                         noise_phase_q;
  logic [SW-1:0]                         noise_shifter_q;
  logic                                  noise_level_q;
  logic signed [YW-1:0]                  prev_q;

  // Working registers
  logic signed [MW-1:0] mix_q;
  logic [PW-1:0]        step2_q;
  logic [2*UW-1:0]      prod_q;
  logic signed [YW-1:0] sample_q;

  logic in_accept, wr_en, tick, out_free;
  logic div_start, div_done;
  logic [PW-1:0] div_step;

  logic [PW-1:0]                 cur_phase;
  logic [psg_pkg::SCALE_W-1:0]   tone_scale;
  logic signed [MW-1:0]          tone_term;
  logic [PW-1:0]                 noise_step;
  logic [PW-1:0]                 noise_next;
  logic                          noise_flip;
  logic                          noise_fb;
  logic [SW-1:0]                 shifted;
  logic [SW-1:0]                 shift_new;
  logic                          level_new;
  logic [psg_pkg::SCALE_W-1:0]   noise_scale;
  logic signed [MW-1:0]          noise_term;
  logic signed [FW-1:0]          filt_sum;
  logic signed [FW-1:0]          filt_off;
  logic [UW-1:0]                 filt_u;
  logic [YW-1:0]                 quot;
  logic signed [YW-1:0]          y;

  // Handshakes
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign wr_en      = in_accept && (action_i == psg_pkg::ACT_WRITE);
  assign tick       = in_accept && (action_i == psg_pkg::ACT_TICK);
  assign out_free   = !out_valid_q || out_ready_i;

  psg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (data_i),
    .cfg_o     (cfg)
  );

  assign div_start = (state_q == ST_DIV_START);

  psg_div #(
    .PHASE_FRAC (F)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .period_i (cfg.tone_period[ch_q]),
    .done_o   (div_done),
    .step_o   (div_step)
  );

  // Tone contribution, from the phase bit before the add
  assign cur_phase  = tone_phase_q[ch_q];
  assign tone_scale = psg_pkg::voice_scale(cfg.tone_atten[ch_q]);
  assign tone_term  = cur_phase[F] ? MW'(signed'({1'b0, tone_scale}))
                                   : -MW'(signed'({1'b0, tone_scale}));

  // Noise step select
  always_comb begin
    case (cfg.noise_ctrl[1:0])
      psg_pkg::NOISE_RATE_FAST:  noise_step = NSTEP_FAST;
      psg_pkg::NOISE_RATE_MID:   noise_step = NSTEP_MID;
      psg_pkg::NOISE_RATE_SLOW:  noise_step = NSTEP_SLOW;
      psg_pkg::NOISE_RATE_TONE2: noise_step = step2_q;
      default:                   noise_step = step2_q;
    endcase
  end

  // Noise shift on a change of the phase integer bit
  assign noise_next  = noise_phase_q + noise_step;
  assign noise_flip  = noise_next[F] ^ noise_phase_q[F];
  assign noise_fb    = noise_shifter_q[0] ^ (cfg.noise_ctrl[2] & noise_shifter_q[3]);
  assign shifted     = {noise_fb, noise_shifter_q[SW-1:1]};
  assign shift_new   = (shifted == '0) ? psg_pkg::NOISE_SEED : shifted;
  assign level_new   = noise_flip ? shift_new[0] : noise_level_q;
  assign noise_scale = psg_pkg::voice_scale(cfg.noise_atten);
  assign noise_term  = level_new ? MW'(signed'({1'b0, noise_scale}))
                                 : -MW'(signed'({1'b0, noise_scale}));

  // Smoother: offset keeps the dividend positive
  assign filt_sum = FW'(mix_q) + (FW'(prev_q) <<< 3) + FW'(prev_q);
  assign filt_off = filt_sum + FILT_OFFSET;
  assign filt_u   = filt_off[UW-1:0];
  // quotient is 0..65535, so subtracting 32768 is a flip of the top bit
  assign quot     = prod_q[RECIP_SHIFT +: YW];
  assign y        = signed'({~quot[YW-1], quot[YW-2:0]});

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (tick) begin
          ch_d    = '0;
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (ch_q == LAST_TONE) begin
            state_d = ST_NOISE;
          end else begin
            ch_d    = ch_q + psg_pkg::CH_W'(1);
            state_d = ST_DIV_START;
          end
        end
      end
      ST_NOISE: begin
        state_d = ST_FILT_MUL;
      end
      ST_FILT_MUL: begin
        state_d = ST_FILT_OUT;
      end
      ST_FILT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Voice state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_phase_q    <= '0;
      noise_phase_q   <= '0;
      noise_shifter_q <= '0;
      noise_level_q   <= 1'b0;
      prev_q          <= '0;
    end else begin
      if (cfg.noise_reload) begin
        noise_shifter_q <= psg_pkg::NOISE_SEED;
      end
      if (state_q == ST_DIV_WAIT && div_done) begin
        tone_phase_q[ch_q] <= cur_phase + div_step;
      end
      if (state_q == ST_NOISE) begin
        noise_phase_q <= noise_next;
        if (noise_flip) begin
          noise_shifter_q <= shift_new;
          noise_level_q   <= shift_new[0];
        end
      end
      if (state_q == ST_FILT_OUT && out_free) begin
        prev_q <= y;
      end
    end
  end

  // Mix accumulation and filter pipeline
  always_ff @(posedge clk_i) begin
    if (tick) begin
      mix_q <= '0;
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      mix_q <= mix_q + tone_term;
      if (ch_q == LAST_TONE) begin
        step2_q <= div_step;
      end
    end
    if (state_q == ST_NOISE) begin
      mix_q <= mix_q + noise_term;
    end
    if (state_q == ST_FILT_MUL) begin
      prod_q <= filt_u * RECIP;
    end
    if (state_q == ST_FILT_OUT && out_free) begin
      sample_q <= y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // Checks
  `PSG_ASSERT(a_done_in_wait, clk_i, rst_ni, div_done |-> (state_q == ST_DIV_WAIT))
  `PSG_ASSERT(a_tone_index, clk_i, rst_ni, (state_q != ST_IDLE) |-> (ch_q != 2'd3))
  `PSG_ASSERT_NEXT(a_shifter_nonzero, clk_i, rst_ni, (noise_shifter_q != '0), (noise_shifter_q != '0))
  `PSG_ASSERT_NEXT(a_result_held, clk_i, rst_ni, (state_q == ST_FILT_OUT) && out_valid_q && !out_ready_i, (state_q == ST_FILT_OUT))

endmodule

`default_nettype wire

### hdl/psg_regs.sv
// ----------------------------------------------------------------------------
// PSG register bank
// Decodes latch and data bus bytes into tone, volume and noise registers.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [psg_pkg::DATA_W-1:0]        wr_data_i,
  output psg_pkg::psg_cfg_t                 cfg_o
);

  localparam logic [psg_pkg::CH_W-1:0] TONE_LIMIT = psg_pkg::CH_W'(psg_pkg::NUM_TONES);

  logic [psg_pkg::NUM_TONES-1:0][psg_pkg::PERIOD_W-1:0] period_q;
  logic [psg_pkg::NUM_TONES-1:0][psg_pkg::ATTEN_W-1:0]  atten_q;
  logic [psg_pkg::CH_W-1:0]                             latched_q;
  logic [psg_pkg::NCTL_W-1:0]                           noise_ctrl_q;
  logic [psg_pkg::ATTEN_W-1:0]                          noise_atten_q;

  logic                      is_latch;
  logic [2:0]                sel;
  logic [psg_pkg::CH_W-1:0]  ch;

  assign is_latch = (wr_data_i[7] == psg_pkg::FORM_LATCH);
  assign sel      = wr_data_i[6:4];
  assign ch       = sel[2:1];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= '0;
      atten_q       <= '0;
      latched_q     <= '0;
      noise_ctrl_q  <= '0;
      noise_atten_q <= '0;
    end else if (wr_en_i) begin
      if (!is_latch) begin
        // data byte: upper six period bits of the latched tone
        if (latched_q < TONE_LIMIT) begin
          period_q[latched_q][psg_pkg::PERIOD_W-1:4] <= wr_data_i[5:0];
        end
      end else begin
        unique case (sel) inside
          psg_pkg::SEL_TONE0, psg_pkg::SEL_TONE1, psg_pkg::SEL_TONE2: begin
            latched_q         <= ch;
            period_q[ch][3:0] <= wr_data_i[3:0];
          end
          psg_pkg::SEL_ATTEN0, psg_pkg::SEL_ATTEN1, psg_pkg::SEL_ATTEN2: begin
            atten_q[ch] <= wr_data_i[3:0];
          end
          psg_pkg::SEL_NOISE_CTRL: begin
            noise_ctrl_q <= wr_data_i[2:0];
          end
          psg_pkg::SEL_NOISE_ATTEN: begin
            noise_atten_q <= wr_data_i[3:0];
          end
        endcase
      end
    end
  end

  assign cfg_o.tone_period  = period_q;
  assign cfg_o.tone_atten   = atten_q;
  assign cfg_o.noise_ctrl   = noise_ctrl_q;
  assign cfg_o.noise_atten  = noise_atten_q;
  // shifter reload pulse, same edge as the noise control update
  assign cfg_o.noise_reload = wr_en_i && is_latch && (sel == psg_pkg::SEL_NOISE_CTRL);

endmodule

`default_nettype wire

### hdl/psg_div.sv
// ----------------------------------------------------------------------------
// PSG phase step divider
// Restoring divider, one quotient bit per cycle, for the rounded phase step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "psg_tone_noise_generator_defines.svh"

module psg_div #(
  parameter int unsigned PHASE_FRAC = psg_pkg::PHASE_FRAC_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [psg_pkg::PERIOD_W-1:0]     period_i,
  output logic                             done_o,
  output logic [PHASE_FRAC:0]              step_o
);

  // Quotient < 2^(F+3); dividend < 2^(F+19)
  localparam int unsigned QW = PHASE_FRAC + 3;
  localparam int unsigned NW = PHASE_FRAC + 19;
  localparam int unsigned DW = psg_pkg::DEN_W;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam int unsigned PEW = psg_pkg::PERIOD_W + 1;

  localparam logic [NW-1:0] NUM_BASE = NW'(64'(psg_pkg::STEP_NUM_BASE) << PHASE_FRAC);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_e;

  div_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;

  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [QW-1:0] sh_q;
  logic [QW-1:0] quo_q;

  logic [PEW-1:0] period_eff;
  logic [DW-1:0]  den_start;
  logic [NW-1:0]  num;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;

  // Denominator 44100 * period, zero period taken as 1024
  assign period_eff = (period_i == '0) ? PEW'(psg_pkg::ZERO_PERIOD) : {1'b0, period_i};
  assign den_start  = DW'(period_eff) * DW'(psg_pkg::SAMPLE_RATE);

  // Rounded numerator: base plus half the (even) denominator
  assign num = NUM_BASE + NW'(den_q >> 1);

  // One restoring step
  assign trial = {rem_q, sh_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          state_d = DIV_LOAD;
        end
      end
      DIV_LOAD: begin
        state_d = DIV_RUN;
        cnt_d   = CW'(QW);
      end
      DIV_RUN: begin
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = DIV_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      den_q <= den_start;
    end
    if (state_q == DIV_LOAD) begin
      rem_q <= DW'(num[NW-1:QW]);
      sh_q  <= num[QW-1:0];
      quo_q <= '0;
    end
    if (state_q == DIV_RUN) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_q  <= {sh_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign step_o = quo_q[PHASE_FRAC:0];

  // Checks
  `PSG_ASSERT(a_div_rem_below_den, clk_i, rst_ni, (state_q == DIV_RUN) |-> (rem_q < den_q))
  `PSG_ASSERT(a_div_start_when_idle, clk_i, rst_ni, start_i |-> (state_q == DIV_IDLE))
  `PSG_ASSERT(a_div_done_idle, clk_i, rst_ni, done_q |-> (state_q == DIV_IDLE))

endmodule

`default_nettype wire

### tb/sv/psg_tone_noise_generator_test.sv
// ----------------------------------------------------------------------------
// PSG tone and noise generator testbench
// Drives bus write and tick requests through the valid/ready input channel,
// predicts every smoothed sample with a cycle-free model of the voices and
// the noise shifter, and compares each sample taken from the output channel
// in order. Sender gaps and receiver stalls vary in four pressure phases.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = psg_pkg::PHASE_FRAC_DEF;
  localparam int unsigned DIRECTED_ITEMS = 25;
  localparam int unsigned RANDOM_ITEMS = 925;

  // Expected sample store and register/voice predictor
  class psg_sample_scoreboard;
    logic [psg_pkg::PERIOD_W-1:0]   period [psg_pkg::NUM_TONES];
    logic [psg_pkg::ATTEN_W-1:0]    tone_atten [psg_pkg::NUM_TONES];
    logic [psg_pkg::CH_W-1:0]       latched;
    logic [psg_pkg::NCTL_W-1:0]     noise_ctrl;
    logic [psg_pkg::ATTEN_W-1:0]    noise_atten;
    logic [FRAC:0]                  tone_phase [psg_pkg::NUM_TONES];
    logic [FRAC:0]                  noise_phase;
    logic [psg_pkg::SHIFT_W-1:0]    shifter;
    logic                           noise_level;
    int                             prev_sample;
    logic signed [psg_pkg::SAMPLE_W-1:0] expected_samples [$];
    int unsigned mismatches, samples_checked, ticks, writes;

    function new();
      foreach (period[c]) begin
        period[c] = '0;
        tone_atten[c] = '0;
        tone_phase[c] = '0;
      end
      latched = '0;
      noise_ctrl = '0;
      noise_atten = '0;
      noise_phase = '0;
      shifter = '0;
      noise_level = 1'b0;
      prev_sample = 0;
      mismatches = 0;
      samples_checked = 0;
      ticks = 0;
      writes = 0;
    endfunction

    // Phase increment per sample for a divider period (0 reads as 1024)
    function automatic logic [FRAC:0] step_for_period(int unsigned per);
      longint unsigned num, den;
      num = longint'(psg_pkg::STEP_NUM_BASE) << FRAC;
      den = longint'(psg_pkg::SAMPLE_RATE) *
            longint'((per == 0) ? psg_pkg::ZERO_PERIOD : per);
      return (FRAC + 1)'((num + den / 2) / den);
    endfunction

    // Square-wave amplitude in Q15 for an attenuation code
    function automatic int amplitude_of(logic [psg_pkg::ATTEN_W-1:0] a);
      return (8192 * (15 - int'(a)) + 7) / 15;
    endfunction

    function void decode_byte(logic [psg_pkg::DATA_W-1:0] bus_byte);
      psg_pkg::psg_reg_sel_e sel;
      sel = psg_pkg::psg_reg_sel_e'(bus_byte[6:4]);
      writes++;
      if (bus_byte[7] == psg_pkg::FORM_DATA) begin
        if (latched < psg_pkg::NUM_TONES) period[latched][9:4] = bus_byte[5:0];
      end else if (sel == psg_pkg::SEL_NOISE_CTRL) begin
        noise_ctrl = bus_byte[2:0];
        shifter = psg_pkg::NOISE_SEED;
      end else if (sel == psg_pkg::SEL_NOISE_ATTEN) begin
        noise_atten = bus_byte[3:0];
      end else if (sel[0]) begin
        tone_atten[sel[2:1]] = bus_byte[3:0];
      end else begin
        latched = sel[2:1];
        period[sel[2:1]][3:0] = bus_byte[3:0];
      end
    endfunction

    function void render_tick();
      logic [FRAC:0] steps [psg_pkg::NUM_TONES];
      logic [FRAC:0] nstep, nxt;
      logic fb;
      int mix, amp, t, y;
      mix = 0;
      ticks++;
      for (int c = 0; c < psg_pkg::NUM_TONES; c++) begin
        steps[c] = step_for_period(period[c]);
        amp = amplitude_of(tone_atten[c]);
        mix += tone_phase[c][FRAC] ? amp : -amp;
        tone_phase[c] = tone_phase[c] + steps[c];
      end
      case (noise_ctrl[1:0])
        psg_pkg::NOISE_RATE_FAST: nstep = step_for_period(psg_pkg::NOISE_PER_FAST);
        psg_pkg::NOISE_RATE_MID:  nstep = step_for_period(psg_pkg::NOISE_PER_MID);
        psg_pkg::NOISE_RATE_SLOW: nstep = step_for_period(psg_pkg::NOISE_PER_SLOW);
        default:                  nstep = steps[2];
      endcase
      nxt = noise_phase + nstep;
      // noise clocks on a change of the integer phase bit
      if (nxt[FRAC] != noise_phase[FRAC]) begin
        fb = shifter[0] ^ (noise_ctrl[2] & shifter[3]);
        shifter = {fb, shifter[psg_pkg::SHIFT_W-1:1]};
        if (shifter == '0) shifter = psg_pkg::NOISE_SEED;
        noise_level = shifter[0];
      end
      amp = amplitude_of(noise_atten);
      mix += noise_level ? amp : -amp;
      noise_phase = nxt;
      // one-pole smoother, rounded half up, offset keeps the division positive
      t = mix + 9 * prev_sample;
      y = (t + 327680 + 5) / 10 - 32768;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      prev_sample = y;
      expected_samples.push_back(psg_pkg::SAMPLE_W'(y));
    endfunction

    function void take_request(logic act, logic [psg_pkg::DATA_W-1:0] bus_byte);
      if (act == psg_pkg::ACT_TICK) render_tick();
      else decode_byte(bus_byte);
    endfunction

    function void check_sample(logic signed [psg_pkg::SAMPLE_W-1:0] got);
      logic signed [psg_pkg::SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample: none expected, actual %0d", got);
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      samples_checked++;
      if (got !== want) begin
        $error("sample: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic                                action_i = psg_pkg::ACT_WRITE;
  logic [psg_pkg::DATA_W-1:0]          data_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [psg_pkg::SAMPLE_W-1:0] sample_o;

  psg_sample_scoreboard board = new();
  int unsigned gap_pct = 0;
  int unsigned hold_pct = 0;
  int unsigned requests_sent = 0;

  psg_pkg::psg_reg_sel_e tone_sel [psg_pkg::NUM_TONES] =
    '{psg_pkg::SEL_TONE0, psg_pkg::SEL_TONE1, psg_pkg::SEL_TONE2};
  psg_pkg::psg_reg_sel_e atten_sel [psg_pkg::NUM_TONES] =
    '{psg_pkg::SEL_ATTEN0, psg_pkg::SEL_ATTEN1, psg_pkg::SEL_ATTEN2};

  psg_tone_noise_generator #(
    .PHASE_FRACTION_BITS(FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .data_i     (data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sample_o   (sample_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [psg_pkg::DATA_W-1:0] latch_byte(psg_pkg::psg_reg_sel_e sel,
                                                             logic [3:0] nib);
    return {psg_pkg::FORM_LATCH, sel, nib};
  endfunction

  function automatic logic [psg_pkg::DATA_W-1:0] data_byte(logic [6:0] bits);
    return {psg_pkg::FORM_DATA, bits};
  endfunction

  // Present one request from a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic act, input logic [psg_pkg::DATA_W-1:0] bus_byte);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      action_i <= 1'($urandom_range(1));
      data_i <= psg_pkg::DATA_W'($urandom_range(255));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    data_i <= bus_byte;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_request(act, bus_byte);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_request(psg_pkg::ACT_TICK, psg_pkg::DATA_W'($urandom_range(255)));
  endtask

  task automatic send_write(input logic [psg_pkg::DATA_W-1:0] bus_byte);
    send_request(psg_pkg::ACT_WRITE, bus_byte);
  endtask

  // One random stretch of bus traffic, mostly well-formed register updates
  task automatic random_scene();
    int unsigned pick, ch, n;
    logic [3:0] nib;
    pick = $urandom_range(99);
    ch = $urandom_range(psg_pkg::NUM_TONES - 1);
    if (pick < 35) begin
      send_tick();
    end else if (pick < 47) begin
      n = $urandom_range(16, 4);
      repeat (n) send_tick();
    end else if (pick < 65) begin
      // latch then data byte; half the periods stay small so tones toggle fast
      send_write(latch_byte(tone_sel[ch], 4'($urandom_range(15))));
      if ($urandom_range(1)) send_write(data_byte({1'($urandom_range(1)), 6'd0}));
      else send_write(data_byte(7'($urandom_range(127))));
    end else if (pick < 75) begin
      if ($urandom_range(4) == 0) begin
        // everything at full volume for the loudest mixes
        foreach (atten_sel[c]) send_write(latch_byte(atten_sel[c], 4'd0));
        send_write(latch_byte(psg_pkg::SEL_NOISE_ATTEN, 4'd0));
      end else begin
        nib = ($urandom_range(3) == 0) ? 4'($urandom_range(1) * 15) : 4'($urandom_range(15));
        send_write(latch_byte(atten_sel[ch], nib));
      end
    end else if (pick < 82) begin
      send_write(latch_byte(psg_pkg::SEL_NOISE_CTRL, 4'($urandom_range(15))));
    end else if (pick < 88) begin
      send_write(latch_byte(psg_pkg::SEL_NOISE_ATTEN, 4'($urandom_range(15))));
    end else if (pick < 93) begin
      send_write(data_byte(7'($urandom_range(127))));
    end else begin
      send_write(psg_pkg::DATA_W'($urandom_range(255)));
    end
  endtask

  // Receiver: ready changes at the falling edge, samples taken at the rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= hold_pct);
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) board.check_sample(sample_o);
    end
  end

  // Watchdog
  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned gap_tab [4] = '{0, 72, 0, 18};
    int unsigned hold_tab [4] = '{0, 0, 72, 18};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero periods and an empty shifter straight out of reset
    repeat (4) send_tick();
    // data form before any latch goes to tone 0
    send_write(data_byte(7'h3f));
    send_write(latch_byte(psg_pkg::SEL_TONE0, 4'hf));
    send_write(latch_byte(psg_pkg::SEL_TONE1, 4'h1));
    send_write(data_byte(7'h40));
    send_write(latch_byte(psg_pkg::SEL_TONE2, 4'h0));
    send_write(data_byte(7'h00));
    send_write(latch_byte(psg_pkg::SEL_ATTEN0, 4'hf));
    send_write(latch_byte(psg_pkg::SEL_ATTEN1, 4'h0));
    send_write(latch_byte(psg_pkg::SEL_ATTEN2, 4'h7));
    send_write(latch_byte(psg_pkg::SEL_NOISE_ATTEN, 4'h0));
    // white noise clocked by tone 2, then the middle and slow fixed rates
    send_write(latch_byte(psg_pkg::SEL_NOISE_CTRL, 4'h7));
    repeat (2) send_tick();
    send_write(latch_byte(psg_pkg::SEL_NOISE_CTRL, 4'h1));
    send_tick();
    send_write(latch_byte(psg_pkg::SEL_NOISE_CTRL, 4'h2));
    send_tick();
    send_write(latch_byte(psg_pkg::SEL_NOISE_CTRL, 4'he));
    send_tick();
    send_write(latch_byte(psg_pkg::SEL_NOISE_ATTEN, 4'hf));
    send_tick();

    for (int p = 0; p < 4; p++) begin
      gap_pct = gap_tab[p];
      hold_pct = hold_tab[p];
      while (requests_sent < DIRECTED_ITEMS + (p + 1) * RANDOM_ITEMS / 4) random_scene();
    end
    in_valid_i <= 1'b0;

    while (board.expected_samples.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d requests: %0d bus writes and %0d ticks over four pressure phases",
             requests_sent, board.writes, board.ticks);
    $display("Compared %0d samples, %0d mismatches", board.samples_checked,
             board.mismatches);
    if (board.mismatches == 0 && board.expected_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/psg_pkg.sv
hdl/psg_regs.sv
hdl/psg_div.sv
hdl/psg_tone_noise_generator.sv
tb/sv/psg_tone_noise_generator_test.sv
